/* rtl/srmm_pkg.sv */
// Shared types, codes and helpers of the sparse row matrix multiply block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package srmm_pkg;

	localparam int MAX_DIM_DEF     = 64;
	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int VALUE_BITS_DEF  = 16;

	localparam int IDX_W      = 6;
	localparam int REG_W      = 7;
	localparam int IN_VAL_W   = 16;
	localparam int ACC_W      = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 3;

	localparam logic [REG_W-1:0] DIM_RESET = REG_W'(64);

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_LOAD_A  = 2'd1,
		REQ_LOAD_B  = 2'd2,
		REQ_COMPUTE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ORDER = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Load request from the sequencer to one entry store.
	typedef struct packed {
		logic                        en;
		logic [IDX_W-1:0]            row;
		logic [IDX_W-1:0]            col;
		logic signed [IN_VAL_W-1:0]  value;
	} load_req_t;

	// What a store reports back about a pending load.
	typedef struct packed {
		status_t status;
		logic    busy;
	} store_stat_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic logic [REG_W-1:0] cap_dim(input logic [REG_W-1:0] v,
		input int unsigned lim);
		return (32'(v) > lim) ? REG_W'(lim) : v;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/srmm_store.sv */
// Compressed-row entry store for one matrix: entry memories, row start memory,
// fill count and load checks. Depends on srmm_pkg.
`default_nettype none
module srmm_store #(
	parameter int MAX_DIM     = srmm_pkg::MAX_DIM_DEF,
	parameter int MAX_ENTRIES = srmm_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_BITS  = srmm_pkg::VALUE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      clear,
	input  srmm_pkg::load_req_t                       ld,
	input  logic [srmm_pkg::REG_W-1:0]                row_lim,
	input  logic [srmm_pkg::REG_W-1:0]                col_lim,
	output srmm_pkg::store_stat_t                     stat,
	input  logic [$clog2(MAX_DIM+1)-1:0]              start_addr,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]          start_data,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]          count,
	output logic [srmm_pkg::IDX_W-1:0]                last_row,
	input  logic [$clog2(MAX_ENTRIES)-1:0]            entry_addr,
	output logic [srmm_pkg::IDX_W-1:0]                entry_col,
	output logic signed [VALUE_BITS-1:0]              entry_val
);
	import srmm_pkg::*;

	localparam int SW = $clog2(MAX_DIM + 1);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam logic signed [32:0] VMAX = 33'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
	localparam logic signed [32:0] VMIN = -VMAX - 33'sd1;

	logic [IDX_W-1:0]            col_mem [MAX_ENTRIES];
	logic signed [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
	logic [CW-1:0]               start_mem [MAX_DIM+1];

	logic [CW-1:0]    count_q;
	logic [IDX_W-1:0] last_q;
	logic             fill_act_q;
	logic [SW-1:0]    fill_ptr_q;
	logic [SW-1:0]    fill_end_q;
	logic [CW-1:0]    fill_val_q;
	logic [CW-1:0]    start_rd_q;
	logic             start_zero_q;

	logic signed [32:0]           vx;
	logic signed [VALUE_BITS-1:0] vsat;
	logic                         store_ok;

	always_comb begin
		vx = 33'(ld.value);
		if (vx > VMAX) begin
			vsat = VALUE_BITS'(VMAX);
		end else if (vx < VMIN) begin
			vsat = VALUE_BITS'(VMIN);
		end else begin
			vsat = VALUE_BITS'(vx);
		end
	end

	always_comb begin
		if ({1'b0, ld.row} >= row_lim || {1'b0, ld.col} >= col_lim) begin
			stat.status = ST_RANGE;
		end else if (ld.row < last_q) begin
			stat.status = ST_ORDER;
		end else if (count_q >= CW'(MAX_ENTRIES)) begin
			stat.status = ST_FULL;
		end else begin
			stat.status = ST_OK;
		end
		stat.busy = fill_act_q;
	end

	assign store_ok = ld.en && (stat.status == ST_OK);

	// Row starts of rows a load skips, and of its own row, fill one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			last_q     <= '0;
			fill_act_q <= 1'b0;
			fill_ptr_q <= '0;
			fill_end_q <= '0;
			fill_val_q <= '0;
		end else if (clear) begin
			count_q    <= '0;
			last_q     <= '0;
			fill_act_q <= 1'b0;
		end else if (store_ok) begin
			count_q    <= count_q + CW'(1);
			last_q     <= ld.row;
			fill_act_q <= ld.row > last_q;
			fill_ptr_q <= SW'(last_q) + SW'(1);
			fill_end_q <= SW'(ld.row);
			fill_val_q <= count_q;
		end else if (fill_act_q) begin
			fill_ptr_q <= fill_ptr_q + SW'(1);
			if (fill_ptr_q == fill_end_q) begin
				fill_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_ok) begin
			col_mem[count_q[EW-1:0]] <= ld.col;
			val_mem[count_q[EW-1:0]] <= vsat;
		end
		entry_col <= col_mem[entry_addr];
		entry_val <= val_mem[entry_addr];
	end

	always_ff @(posedge clk) begin
		if (fill_act_q) begin
			start_mem[fill_ptr_q] <= fill_val_q;
		end
		start_rd_q   <= start_mem[start_addr];
		start_zero_q <= start_addr == '0;
	end

	// Row zero always starts at entry zero and is never written.
	assign start_data = start_zero_q ? '0 : start_rd_q;
	assign count      = count_q;
	assign last_row   = last_q;

endmodule
`default_nettype wire

/* rtl/srmm_mac.sv */
// Shared multiply and saturating accumulate unit: registered product, then add.
// Depends on srmm_pkg.
`default_nettype none
module srmm_mac #(
	parameter int VALUE_BITS = srmm_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               mul_en,
	input  logic signed [VALUE_BITS-1:0]       a,
	input  logic signed [VALUE_BITS-1:0]       b,
	input  logic signed [srmm_pkg::ACC_W-1:0]  acc_in,
	output logic signed [srmm_pkg::ACC_W-1:0]  prod,
	output logic signed [srmm_pkg::ACC_W-1:0]  sum
);
	import srmm_pkg::*;

	localparam int PW = 2 * VALUE_BITS;
	localparam int XW = (PW > ACC_W) ? PW : ACC_W + 1;
	localparam logic signed [XW-1:0] HI = XW'(ACC_MAX);
	localparam logic signed [XW-1:0] LO = XW'(ACC_MIN);

	logic signed [PW-1:0] p_full;
	logic signed [XW-1:0] p_x;

	assign p_full = a * b;
	assign p_x    = XW'(p_full);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			if (p_x > HI) begin
				prod <= ACC_MAX;
			end else if (p_x < LO) begin
				prod <= ACC_MIN;
			end else begin
				prod <= ACC_W'(p_x);
			end
		end
	end

	assign sum = sat_add(acc_in, prod);

endmodule
`default_nettype wire

/* rtl/sparse_row_matrix_multiply_top.sv */
// Top level of the sparse row matrix multiply block: sequencer, column slot map,
// row accumulators and output register. Depends on srmm_pkg, srmm_store, srmm_mac.
//
// Computes one row of C = A*B per compute beat, Gustavson style, with one shared
// multiply-accumulate unit stepped by a sequencer. A clear beat is handled in the
// idle state. A load beat then waits until both stores have filled the row starts
// of the rows that it moves past the last loaded row. A compute beat walks each
// entry of the A row; for each A entry whose column is in range it walks the B row
// of that column, skips B entries whose column is out of range, and for each
// product opens a new column slot or adds into the accumulator the column already
// has; it then emits one result per column, or one empty-row result. The steps
// follow from the registered reads of the entry and accumulator memories. The
// input is not ready while a beat is being worked on, nor while a result waits
// in the output register for the downstream side.
`default_nettype none
module sparse_row_matrix_multiply_top #(
	parameter int MAX_DIM     = srmm_pkg::MAX_DIM_DEF,
	parameter int MAX_ENTRIES = srmm_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_BITS  = srmm_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [srmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srmm_pkg::REG_W-1:0]           cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// row_index[5:0], col_index[11:6], entry_value[27:12], zero fill
	input  logic [srmm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// req_type[1:0]
	input  logic [srmm_pkg::IN_USER_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_row[5:0], out_col[11:6], out_value[51:12], zero fill
	output logic [srmm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status[1:0], row_empty[2]
	output logic [srmm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	output logic                                 m_axis_tlast
);
	import srmm_pkg::*;

	localparam int SW = $clog2(MAX_DIM + 1);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int DW = $clog2(MAX_DIM);
	localparam int NW = $clog2(MAX_DIM + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FILL, S_INIT, S_AR1, S_AR2, S_AF, S_AW,
		S_BR1, S_BR2, S_BF, S_BW, S_SL, S_AC, S_EMIT, S_EL
	} state_t;

	state_t state_q;

	logic [REG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [REG_W-1:0] er, ei, ec;

	req_t                  in_req;
	logic [IDX_W-1:0]      in_row, in_col;
	logic signed [IN_VAL_W-1:0] in_val;
	logic                  accept, out_free, diag;

	logic [IDX_W-1:0]      r_q, ja_q, jb_q;
	logic [CW-1:0]         ia_q, aend_q, ib_q, bend_q;
	logic signed [VALUE_BITS-1:0] av_q;
	logic [NW-1:0]         n_q, k_q;
	logic [MAX_DIM-1:0]    slot_valid_q;

	logic                  m_valid_q;
	status_t               o_status_q;
	logic [IDX_W-1:0]      o_row_q, o_col_q;
	logic signed [ACC_W-1:0] o_val_q;
	logic                  o_empty_q, o_last_q;

	load_req_t             a_ld, b_ld;
	store_stat_t           a_stat, b_stat;
	logic [SW-1:0]         a_start_addr, b_start_addr;
	logic [CW-1:0]         a_start_data, b_start_data, a_count, b_count;
	logic [IDX_W-1:0]      a_last, b_last, a_entry_col, b_entry_col;
	logic signed [VALUE_BITS-1:0] a_entry_val, b_entry_val;
	logic                  clear;

	logic [DW-1:0]         slot_map_mem [MAX_DIM];
	logic [IDX_W-1:0]      slot_col_mem [MAX_DIM];
	logic signed [ACC_W-1:0] acc_mem [MAX_DIM];
	logic [DW-1:0]         slot_map_rd;
	logic [IDX_W-1:0]      slot_col_rd;
	logic signed [ACC_W-1:0] acc_rd;

	logic                  map_we, col_we, acc_we;
	logic [DW-1:0]         map_waddr, map_wdata, col_waddr, acc_waddr, map_raddr, acc_raddr;
	logic [IDX_W-1:0]      col_wdata;
	logic signed [ACC_W-1:0] acc_wdata;

	logic                  mul_en, new_slot;
	logic signed [ACC_W-1:0] prod, sum;
	logic [CW-1:0]         rng_beg, rng_end;

	assign in_req = req_t'(s_axis_tuser);
	assign in_row = s_axis_tdata[IDX_W-1:0];
	assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_val = s_axis_tdata[2*IDX_W+IN_VAL_W-1:2*IDX_W];

	assign er = cap_dim(rows_a_q, MAX_DIM);
	assign ei = cap_dim(inner_dim_q, MAX_DIM);
	assign ec = cap_dim(cols_b_q, MAX_DIM);
	assign diag = rows_a_q == cols_b_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_A:    rows_a_q    <= cfg_data;
				CFG_INNER_DIM: inner_dim_q <= cfg_data;
				CFG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign clear = accept && (in_req == REQ_CLEAR);
	assign a_ld  = '{en: accept && (in_req == REQ_LOAD_A), row: in_row, col: in_col,
		value: in_val};
	assign b_ld  = '{en: accept && (in_req == REQ_LOAD_B), row: in_row, col: in_col,
		value: in_val};

	assign a_start_addr = (state_q == S_INIT) ? SW'(r_q) : SW'(r_q) + SW'(1);
	assign b_start_addr = (state_q == S_AW) ? SW'(a_entry_col) : SW'(ja_q) + SW'(1);

	srmm_store #(.MAX_DIM(MAX_DIM), .MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS))
	u_store_a (
		.clk(clk), .arst_n(arst_n), .clear(clear), .ld(a_ld),
		.row_lim(er), .col_lim(ei), .stat(a_stat),
		.start_addr(a_start_addr), .start_data(a_start_data),
		.count(a_count), .last_row(a_last),
		.entry_addr(ia_q[EW-1:0]), .entry_col(a_entry_col), .entry_val(a_entry_val)
	);

	srmm_store #(.MAX_DIM(MAX_DIM), .MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS))
	u_store_b (
		.clk(clk), .arst_n(arst_n), .clear(clear), .ld(b_ld),
		.row_lim(ei), .col_lim(ec), .stat(b_stat),
		.start_addr(b_start_addr), .start_data(b_start_data),
		.count(b_count), .last_row(b_last),
		.entry_addr(ib_q[EW-1:0]), .entry_col(b_entry_col), .entry_val(b_entry_val)
	);

	assign mul_en = (state_q == S_BW) && ({1'b0, b_entry_col} < ec);

	srmm_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
		.clk(clk), .mul_en(mul_en), .a(av_q), .b(b_entry_val),
		.acc_in(acc_rd), .prod(prod), .sum(sum)
	);

	// Row range of the row being walked, clamped to the fill count.
	always_comb begin
		rng_beg = '0;
		rng_end = '0;
		if (state_q == S_AR1 || state_q == S_AR2) begin
			rng_beg = (r_q <= a_last) ? a_start_data : a_count;
			if (rng_beg > a_count) rng_beg = a_count;
			rng_end = (r_q < a_last) ? a_start_data : a_count;
			if (rng_end > a_count) rng_end = a_count;
			if (rng_end < ia_q) rng_end = ia_q;
		end else begin
			rng_beg = (ja_q <= b_last) ? b_start_data : b_count;
			if (rng_beg > b_count) rng_beg = b_count;
			rng_end = (ja_q < b_last) ? b_start_data : b_count;
			if (rng_end > b_count) rng_end = b_count;
			if (rng_end < ib_q) rng_end = ib_q;
		end
	end

	assign new_slot = !slot_valid_q[DW'(jb_q)] && (n_q < NW'(MAX_DIM));

	always_comb begin
		map_raddr = (state_q == S_BW) ? DW'(b_entry_col) : DW'(jb_q);
		acc_raddr = (state_q == S_EMIT || state_q == S_EL) ? k_q[DW-1:0] : slot_map_rd;
		map_we    = 1'b0;
		map_waddr = DW'(jb_q);
		map_wdata = n_q[DW-1:0];
		col_we    = 1'b0;
		col_waddr = n_q[DW-1:0];
		col_wdata = jb_q;
		acc_we    = 1'b0;
		acc_waddr = n_q[DW-1:0];
		acc_wdata = prod;
		case (state_q)
			S_INIT: begin
				if (diag) begin
					// The diagonal takes slot zero with a zero sum.
					map_we    = 1'b1;
					map_waddr = DW'(r_q);
					map_wdata = '0;
					col_we    = 1'b1;
					col_waddr = '0;
					col_wdata = r_q;
					acc_we    = 1'b1;
					acc_waddr = '0;
					acc_wdata = '0;
				end
			end
			S_SL: begin
				if (new_slot) begin
					map_we = 1'b1;
					col_we = 1'b1;
					acc_we = 1'b1;
				end
			end
			S_AC: begin
				acc_we    = 1'b1;
				acc_waddr = slot_map_rd;
				acc_wdata = sum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) slot_map_mem[map_waddr] <= map_wdata;
		slot_map_rd <= slot_map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (col_we) slot_col_mem[col_waddr] <= col_wdata;
		slot_col_rd <= slot_col_mem[k_q[DW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
		acc_rd <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			r_q          <= '0;
			ja_q         <= '0;
			jb_q         <= '0;
			ia_q         <= '0;
			aend_q       <= '0;
			ib_q         <= '0;
			bend_q       <= '0;
			av_q         <= '0;
			n_q          <= '0;
			k_q          <= '0;
			slot_valid_q <= '0;
			m_valid_q    <= 1'b0;
			o_status_q   <= ST_OK;
			o_row_q      <= '0;
			o_col_q      <= '0;
			o_val_q      <= '0;
			o_empty_q    <= 1'b0;
			o_last_q     <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						m_valid_q  <= 1'b1;
						o_status_q <= ST_OK;
						o_row_q    <= in_row;
						o_col_q    <= in_col;
						o_val_q    <= '0;
						o_empty_q  <= 1'b0;
						o_last_q   <= 1'b1;
						r_q        <= in_row;
						case (in_req)
							REQ_CLEAR: begin
								o_row_q <= '0;
								o_col_q <= '0;
							end
							REQ_LOAD_A: begin
								o_status_q <= a_stat.status;
								state_q    <= S_FILL;
							end
							REQ_LOAD_B: begin
								o_status_q <= b_stat.status;
								state_q    <= S_FILL;
							end
							REQ_COMPUTE: begin
								if ({1'b0, in_row} >= er) begin
									m_valid_q  <= 1'b1;
									o_status_q <= ST_RANGE;
									o_col_q    <= '0;
								end else begin
									m_valid_q <= m_valid_q && !m_axis_tready;
									state_q   <= S_INIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_FILL: begin
					if (!a_stat.busy && !b_stat.busy) begin
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					slot_valid_q <= '0;
					if (diag) begin
						slot_valid_q[DW'(r_q)] <= 1'b1;
					end
					n_q     <= diag ? NW'(1) : '0;
					k_q     <= '0;
					state_q <= S_AR1;
				end
				S_AR1: begin
					ia_q    <= rng_beg;
					state_q <= S_AR2;
				end
				S_AR2: begin
					aend_q  <= rng_end;
					state_q <= S_AF;
				end
				S_AF: begin
					state_q <= (ia_q < aend_q) ? S_AW : S_EMIT;
				end
				S_AW: begin
					ia_q <= ia_q + CW'(1);
					if ({1'b0, a_entry_col} >= ei) begin
						state_q <= S_AF;
					end else begin
						ja_q    <= a_entry_col;
						av_q    <= a_entry_val;
						state_q <= S_BR1;
					end
				end
				S_BR1: begin
					ib_q    <= rng_beg;
					state_q <= S_BR2;
				end
				S_BR2: begin
					bend_q  <= rng_end;
					state_q <= S_BF;
				end
				S_BF: begin
					state_q <= (ib_q < bend_q) ? S_BW : S_AF;
				end
				S_BW: begin
					ib_q <= ib_q + CW'(1);
					if (mul_en) begin
						jb_q    <= b_entry_col;
						state_q <= S_SL;
					end else begin
						state_q <= S_BF;
					end
				end
				S_SL: begin
					if (slot_valid_q[DW'(jb_q)]) begin
						state_q <= S_AC;
					end else begin
						// Columns beyond the slot count are dropped.
						if (new_slot) begin
							slot_valid_q[DW'(jb_q)] <= 1'b1;
							n_q <= n_q + NW'(1);
						end
						state_q <= S_BF;
					end
				end
				S_AC: begin
					state_q <= S_BF;
				end
				S_EMIT: begin
					if (n_q == '0) begin
						if (out_free) begin
							m_valid_q  <= 1'b1;
							o_status_q <= ST_OK;
							o_row_q    <= r_q;
							o_col_q    <= '0;
							o_val_q    <= '0;
							o_empty_q  <= 1'b1;
							o_last_q   <= 1'b1;
							state_q    <= S_IDLE;
						end
					end else begin
						state_q <= S_EL;
					end
				end
				S_EL: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						o_status_q <= ST_OK;
						o_row_q    <= r_q;
						o_col_q    <= slot_col_rd;
						o_val_q    <= acc_rd;
						o_empty_q  <= 1'b0;
						o_last_q   <= (k_q + NW'(1)) == n_q;
						k_q        <= k_q + NW'(1);
						state_q    <= ((k_q + NW'(1)) == n_q) ? S_IDLE : S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - ACC_W - 2*IDX_W){1'b0}}, o_val_q, o_col_q, o_row_q};
	assign m_axis_tuser  = {o_empty_q, o_status_q};
	assign m_axis_tlast  = o_last_q;

endmodule
`default_nettype wire

/* rtl/srmm_chk.sv */
// Port-level checker for the sparse row matrix multiply block, with its bind.
// Depends on srmm_pkg and sparse_row_matrix_multiply_top.
`default_nettype none
module srmm_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [srmm_pkg::IN_USER_W-1:0]       s_axis_tuser,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [srmm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input logic [srmm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	input logic                                 m_axis_tlast
);
	import srmm_pkg::*;

	// A result that is stalled blocks new input beats.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while a result is stalled");

	// Clear and load beats give their single result in the next cycle.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_COMPUTE)
		|=> (m_axis_tvalid && m_axis_tlast))
		else $error("clear or load result missing");

	// Input is not ready in the cycle after a load is accepted.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD_A
			|| s_axis_tuser == REQ_LOAD_B)) |=> !s_axis_tready)
		else $error("ready right after a load");

	// An empty row result is alone and carries ok status.
	a_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tlast && m_axis_tuser[1:0] == ST_OK))
		else $error("malformed empty row result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind sparse_row_matrix_multiply_top srmm_chk u_srmm_chk (.*);
`default_nettype wire
